### src/stream_pattern_replace_unit_assert.svh
// assertion helpers for the pattern replace unit
// expects aclk and aresetn in the enclosing scope
`ifndef STREAM_PATTERN_REPLACE_UNIT_ASSERT_SVH
`define STREAM_PATTERN_REPLACE_UNIT_ASSERT_SVH

// property that must hold at every edge out of reset
`define SPR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// condition that must hold in the cycle after a trigger
`define SPR_ASSERT_NEXT(label, trig, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (trig) |=> (post)) else $error(msg);

`endif

### src/spr_pkg.sv
`timescale 1ns / 1ps

package spr_pkg;

    localparam int MAX_PATTERN = 8;
    localparam int BYTE_W      = 8;
    localparam int WORD_W      = MAX_PATTERN * BYTE_W;
    localparam int CNT_W       = 4;
    localparam int CFG_IDX_W   = 2;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH      = 2'd2;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    // window state carried between steps
    typedef struct packed {
        word_t window;
        cnt_t  fill;
        cnt_t  protect;
    } spr_state_t;

    // bytes leaving in one step, oldest in the low byte
    typedef struct packed {
        word_t bytes;
        cnt_t  count;
        logic  last;
    } spr_emit_t;

endpackage

### src/stream_pattern_replace_unit.sv
`timescale 1ns / 1ps
// path: a byte released by an input transfer goes from the input register into the result buffer
// and is then offered on m_; a byte is released L-1 items after it entered
// throughput: one byte per cycle on both sides while m_ready is high; a packet end releases up to
// eight bytes, drained one per m_ transfer from the result buffer while one more input item waits
// reset: synchronous active low, clears config (length 1), input valid, fill, protect and buffer counts
`include "stream_pattern_replace_unit_assert.svh"

module stream_pattern_replace_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input byte stream
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_data_byte,
    input  logic                          s_packet_end,
    // output byte stream
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_out_byte,
    output logic                          m_out_last,
    // config write port
    input  logic                          cfg_wr_en,
    input  logic [spr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [spr_pkg::WORD_W-1:0]    cfg_wdata
);
    import spr_pkg::*;

    // config registers
    word_t pattern_reg;
    word_t replacement_reg;
    cnt_t  length_reg;
    cnt_t  leff;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_end_reg;

    // window state, contents not reset
    word_t window_reg;
    cnt_t  fill_reg;
    cnt_t  prot_reg;

    // result buffer, oldest byte in the low bits
    word_t ob_data_reg;
    cnt_t  ob_cnt_reg;
    logic  ob_last_reg;

    spr_state_t cur_state;
    spr_state_t nxt_state;
    spr_emit_t  emit;
    logic       proc;
    logic       pop;

    // length 0 acts as 1, anything above the window depth as the depth
    always_comb begin
        if (length_reg == '0) begin
            leff = cnt_t'(1);
        end else if (length_reg > cnt_t'(MAX_PATTERN)) begin
            leff = cnt_t'(MAX_PATTERN);
        end else begin
            leff = length_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg     <= '0;
            replacement_reg <= '0;
            length_reg      <= cnt_t'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_PATTERN:     pattern_reg     <= cfg_wdata;
                CFG_REPLACEMENT: replacement_reg <= cfg_wdata;
                CFG_LENGTH:      length_reg      <= cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // the step runs when an input item is held and the buffer is empty or its last byte leaves this cycle
    assign pop     = m_valid && m_ready;
    assign proc    = in_valid_reg && ((ob_cnt_reg == '0) || ((ob_cnt_reg == cnt_t'(1)) && m_ready));
    assign s_ready = !in_valid_reg || proc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
            in_end_reg  <= s_packet_end;
        end
    end

    assign cur_state.window  = window_reg;
    assign cur_state.fill    = fill_reg;
    assign cur_state.protect = prot_reg;

    spr_step u_step (
        .cur         (cur_state),
        .data_byte   (in_byte_reg),
        .packet_end  (in_end_reg),
        .pattern     (pattern_reg),
        .replacement (replacement_reg),
        .len         (leff),
        .nxt         (nxt_state),
        .emit        (emit)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            prot_reg <= '0;
        end else if (proc) begin
            fill_reg <= nxt_state.fill;
            prot_reg <= nxt_state.protect;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc) begin
            window_reg <= nxt_state.window;
        end
    end

    // result buffer: load a whole step, then shift one byte out per transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ob_cnt_reg  <= '0;
            ob_last_reg <= 1'b0;
        end else if (proc) begin
            ob_cnt_reg  <= emit.count;
            ob_last_reg <= emit.last;
        end else if (pop) begin
            ob_cnt_reg  <= ob_cnt_reg - cnt_t'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (proc) begin
            ob_data_reg <= emit.bytes;
        end else if (pop) begin
            ob_data_reg <= ob_data_reg >> BYTE_W;
        end
    end

    assign m_valid    = (ob_cnt_reg != '0);
    assign m_out_byte = ob_data_reg[BYTE_W-1:0];
    assign m_out_last = ob_last_reg && (ob_cnt_reg == cnt_t'(1));

    // a replaced region never reaches past the bytes still held
    `SPR_ASSERT(a_prot_within_fill, prot_reg <= fill_reg, "protect count exceeds fill")
    // a packet end empties the window
    `SPR_ASSERT_NEXT(a_end_clears, proc && in_end_reg,
        (fill_reg == '0) && (prot_reg == '0), "window not cleared at packet end")
    // a step that releases bytes mid packet leaves one byte short of the pattern
    `SPR_ASSERT_NEXT(a_fill_after_emit, proc && !in_end_reg && (emit.count != '0),
        fill_reg == $past(leff) - cnt_t'(1), "fill wrong after release")

endmodule

### src/spr_step.sv
`timescale 1ns / 1ps

module spr_step (
    input  spr_pkg::spr_state_t cur,
    input  logic [7:0]          data_byte,
    input  logic                packet_end,
    input  spr_pkg::word_t      pattern,
    input  spr_pkg::word_t      replacement,
    input  spr_pkg::cnt_t       len,
    output spr_pkg::spr_state_t nxt,
    output spr_pkg::spr_emit_t  emit
);
    import spr_pkg::*;

    cnt_t                 f1;
    cnt_t                 drop;
    cnt_t                 p1;
    logic                 full;
    logic                 match;
    logic [5:0]           drop_sh;
    logic [6:0]           keep_sh;
    logic [MAX_PATTERN-1:0] eqv;
    word_t                wa;
    word_t                shifted;
    word_t                rep_sh;
    word_t                w2;

    always_comb begin
        // append the new byte after the held ones
        wa = cur.window;
        wa[{cur.fill[2:0], 3'b000} +: BYTE_W] = data_byte;
        f1   = cur.fill + cnt_t'(1);
        full = (f1 >= len);
        drop = full ? (f1 - len) : '0;
        drop_sh = {drop[2:0], 3'b000};
        keep_sh = {drop + cnt_t'(1), 3'b000};

        // each surplus byte lowers the protect count
        p1 = (cur.protect > drop) ? (cur.protect - drop) : '0;

        shifted = wa >> drop_sh;
        rep_sh  = replacement << drop_sh;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            eqv[i] = (shifted[i*BYTE_W +: BYTE_W] == pattern[i*BYTE_W +: BYTE_W])
                     || (cnt_t'(i) >= len);
        end
        match = full && (p1 == '0) && (&eqv);

        // overwrite the matched region in place
        for (int k = 0; k < MAX_PATTERN; k++) begin
            if (match && (cnt_t'(k) >= drop) && (cnt_t'(k) < f1)) begin
                w2[k*BYTE_W +: BYTE_W] = rep_sh[k*BYTE_W +: BYTE_W];
            end else begin
                w2[k*BYTE_W +: BYTE_W] = wa[k*BYTE_W +: BYTE_W];
            end
        end

        emit.bytes = w2;
        emit.last  = packet_end;
        if (packet_end) begin
            emit.count = f1;
        end else if (full) begin
            emit.count = drop + cnt_t'(1);
        end else begin
            emit.count = '0;
        end

        nxt.window = full ? (w2 >> keep_sh) : wa;
        if (packet_end) begin
            nxt.fill    = '0;
            nxt.protect = '0;
        end else if (full) begin
            nxt.fill = len - cnt_t'(1);
            if (match) begin
                nxt.protect = len - cnt_t'(1);
            end else begin
                nxt.protect = (p1 != '0) ? (p1 - cnt_t'(1)) : '0;
            end
        end else begin
            nxt.fill    = f1;
            nxt.protect = cur.protect;
        end
    end

endmodule

### verif/stream_pattern_replace_unit_checker.sv
`timescale 1ns / 1ps

module stream_pattern_replace_unit_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [7:0]                    s_data_byte,
    input  logic                          s_packet_end,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [7:0]                    m_out_byte,
    input  logic                          m_out_last,
    input  logic                          cfg_wr_en,
    input  logic [spr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [spr_pkg::WORD_W-1:0]    cfg_wdata,
    output int                            mismatches,
    output int                            bytes_outstanding
);
    import spr_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } out_item_t;

    // own copy of the registers
    logic [WORD_W-1:0] pat_word;
    logic [WORD_W-1:0] rep_word;
    logic [CNT_W-1:0]  len_code;

    // search window, oldest byte at index 0
    logic [7:0] win [MAX_PATTERN];
    int         fill;
    int         prot;
    int         errs = 0;

    logic [7:0] released [$];
    out_item_t  bytes_due [$];

    function automatic void release_oldest();
        if (fill == 0) return;
        released.push_back(win[0]);
        for (int i = 1; i < fill; i++) win[i-1] = win[i];
        fill--;
        if (prot > 0) prot--;
    endfunction

    // one input byte through the window, expected bytes appended to bytes_due
    function automatic void replace_step(input logic [7:0] din, input logic fin);
        int        span;
        logic      hit;
        out_item_t item;
        span = (len_code == 0) ? 1 : ((len_code > MAX_PATTERN) ? MAX_PATTERN : len_code);
        released.delete();
        if (fill >= MAX_PATTERN) release_oldest();
        win[fill] = din;
        fill++;
        // surplus after a length change leaves untested
        while (fill > span) release_oldest();
        if (fill == span) begin
            hit = (prot == 0);
            for (int i = 0; i < span; i++) begin
                if (win[i] != pat_word[8*i +: 8]) hit = 1'b0;
            end
            if (hit) begin
                for (int i = 0; i < span; i++) win[i] = rep_word[8*i +: 8];
                prot = span;
            end
            release_oldest();
        end
        if (fin) begin
            while (fill > 0) release_oldest();
            fill = 0;
            prot = 0;
        end
        for (int k = 0; k < released.size(); k++) begin
            item.data = released[k];
            item.last = fin && (k == released.size() - 1);
            bytes_due.push_back(item);
        end
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            pat_word = '0;
            rep_word = '0;
            len_code = 4'd1;
            fill     = 0;
            prot     = 0;
            bytes_due.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_PATTERN:     pat_word = cfg_wdata;
                    CFG_REPLACEMENT: rep_word = cfg_wdata;
                    CFG_LENGTH:      len_code = cfg_wdata[CNT_W-1:0];
                    default: ;
                endcase
            end
            // compare before predicting: a new byte cannot leave in its own cycle
            if (m_valid && m_ready) begin
                if (bytes_due.size() == 0) begin
                    errs++;
                    $error("out_byte: no byte expected, got %02h", m_out_byte);
                end else begin
                    want = bytes_due.pop_front();
                    if (m_out_byte !== want.data) begin
                        errs++;
                        $error("out_byte: expected %02h, got %02h", want.data, m_out_byte);
                    end
                    if (m_out_last !== want.last) begin
                        errs++;
                        $error("out_last: expected %0b, got %0b", want.last, m_out_last);
                    end
                end
            end
            if (s_valid && s_ready) replace_step(s_data_byte, s_packet_end);
        end
        mismatches        <= errs;
        bytes_outstanding <= bytes_due.size();
    end

endmodule

### verif/stream_pattern_replace_unit_test.sv
`timescale 1ns / 1ps

module stream_pattern_replace_unit_test;
    import spr_pkg::*;

    localparam int RESET_CYCLES    = 12;
    // input register plus result buffer, with margin for a held byte
    localparam int SETTLE_CYCLES   = 8;
    // long enough to fill the result buffer and stall the input side
    localparam int HOLD_OFF_CYCLES = 80;
    // cycles without any transfer before the run is declared hung
    localparam int STUCK_LIMIT     = 2000;
    localparam int PHASE_ITEMS     = 80;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [7:0]           s_data_byte;
    logic                 s_packet_end;
    logic                 m_valid;
    logic                 m_ready;
    logic [7:0]           m_out_byte;
    logic                 m_out_last;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0]    cfg_wdata;

    int mismatches;
    int bytes_outstanding;

    // idle odds per cycle, in percent
    int   send_idle_pct;
    int   recv_idle_pct;
    logic hold_off_req;
    int   stuck_cycles = 0;
    int   items_sent;

    // what the stimulus knows of the current setting, to plant matches
    logic [WORD_W-1:0] cur_pat;
    int                cur_span;
    logic [7:0]        alpha [2];

    stream_pattern_replace_unit i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_packet_end (s_packet_end),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_out_last   (m_out_last),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    stream_pattern_replace_unit_checker i_check (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_data_byte       (s_data_byte),
        .s_packet_end      (s_packet_end),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_out_byte        (m_out_byte),
        .m_out_last        (m_out_last),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .mismatches        (mismatches),
        .bytes_outstanding (bytes_outstanding)
    );

    // 2 ns clock, starting low so the first edge sees driven inputs
    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // one byte transfer on the input side, with a random gap in front
    task automatic send_byte(input logic [7:0] data, input logic fin);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid      <= 1'b1;
        s_data_byte  <= data;
        s_packet_end <= fin;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // sender pauses until every predicted byte has come out, then lets
    // any byte still sitting in the input register settle into the window
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (bytes_outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // back to back register writes, enable dropped after the last one
    task automatic load_config(input logic [WORD_W-1:0] pat, input logic [WORD_W-1:0] rep,
                               input logic [CNT_W-1:0] code);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_PATTERN;
        cfg_wdata <= pat;
        @(posedge aclk);
        cfg_index <= CFG_REPLACEMENT;
        cfg_wdata <= rep;
        @(posedge aclk);
        cfg_index <= CFG_LENGTH;
        cfg_wdata <= WORD_W'(code);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_pat  = pat;
        cur_span = (code == 0) ? 1 : ((code > MAX_PATTERN) ? MAX_PATTERN : code);
    endtask

    // pattern drawn mostly from a two-byte alphabet so that partial and
    // self-overlapping matches show up often
    task automatic random_config();
        logic [WORD_W-1:0] pat;
        logic [WORD_W-1:0] rep;
        logic [CNT_W-1:0]  code;
        alpha[0] = 8'($urandom);
        alpha[1] = 8'($urandom);
        case ($urandom_range(9))
            0:       code = 4'd0;
            1:       code = 4'($urandom_range(15, 9));
            2:       code = 4'd8;
            default: code = 4'($urandom_range(8, 1));
        endcase
        for (int i = 0; i < MAX_PATTERN; i++) begin
            pat[8*i +: 8] = ($urandom_range(3) == 0) ? 8'($urandom) : alpha[$urandom_range(1)];
        end
        case ($urandom_range(7))
            // replacement equal to the pattern: only the no-overlap rule is visible
            0:       rep = pat;
            1:       rep = '0;
            2:       rep = '1;
            default: rep = {$urandom, $urandom};
        endcase
        load_config(pat, rep, code);
    endtask

    // packet built from whole patterns, pattern prefixes and loose bytes;
    // close low leaves the packet open so its tail meets the next setting
    task automatic send_packet(input int len, input logic close);
        logic [7:0] body [$];
        int         cut;
        while (body.size() < len) begin
            case ($urandom_range(9))
                0, 1, 2, 3: begin
                    for (int i = 0; i < cur_span; i++) body.push_back(cur_pat[8*i +: 8]);
                end
                4, 5: begin
                    cut = $urandom_range(cur_span);
                    for (int i = 0; i < cut; i++) body.push_back(cur_pat[8*i +: 8]);
                end
                default: begin
                    body.push_back(($urandom_range(2) == 0) ? 8'($urandom)
                                                            : alpha[$urandom_range(1)]);
                end
            endcase
        end
        for (int i = 0; i < len; i++) send_byte(body[i], close && (i == len - 1));
    endtask

    // random traffic in segments, each under a fresh setting
    task automatic run_phase(input int snd_pct, input int rcv_pct, input logic press);
        int goal;
        int seg_end;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        goal = items_sent + PHASE_ITEMS;
        while (items_sent < goal) begin
            wait_drained();
            random_config();
            if (press) begin
                // receiver holds off while the sender keeps offering
                hold_off_req = 1'b1;
                press = 1'b0;
            end
            seg_end = items_sent + $urandom_range(50, 20);
            while (items_sent < seg_end) begin
                send_packet($urandom_range(24, 1), $urandom_range(4) != 0);
            end
        end
    endtask

    // result side: random stalls, or one long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // hang detection: any transfer restarts the count
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("stream_pattern_replace_unit: mismatch");
            $finish;
        end
    end

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data_byte   = 8'h00;
        s_packet_end  = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = CFG_PATTERN;
        cfg_wdata     = '0;
        hold_off_req  = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        items_sent    = 0;
        cur_pat       = '0;
        cur_span      = 1;
        alpha[0]      = 8'h00;
        alpha[1]      = 8'hFF;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // reset setting: length 1, zero byte replaced by zero
        send_byte(8'h00, 1'b1);
        wait_drained();

        // "ABA" -> "xyz": leftmost match wins, the candidate starting
        // inside the replaced run is skipped
        load_config(64'h0000_0000_0041_4241, 64'h0000_0000_007A_7978, 4'd3);
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h78, 1'b1);
        // packet shorter than the pattern passes through
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b1);
        wait_drained();

        // zero bytes are plain data and can match
        load_config('0, 64'h0000_0000_0000_FFFF, 4'd2);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        wait_drained();

        // length code zero behaves as one
        load_config('1, '0, 4'd0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h7F, 1'b1);
        wait_drained();

        // length code above the window behaves as a full eight-byte pattern
        load_config('1, 64'h0123_4567_89AB_CDEF, 4'd15);
        repeat (7) send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        wait_drained();

        // length shrinks while three bytes are held: surplus leaves untested
        load_config(64'h0000_0000_4443_4241, 64'h0000_0000_0000_5A59, 4'd4);
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b0);
        send_byte(8'h43, 1'b0);
        wait_drained();
        load_config(64'h0000_0000_4443_4241, 64'h0000_0000_0000_5A59, 4'd2);
        send_byte(8'h44, 1'b1);

        // random traffic: receiver-heavy idling, sender-heavy, then none
        // with one long receiver hold-off
        run_phase(38, 45, 1'b0);
        run_phase(45, 38, 1'b0);
        run_phase(0, 0, 1'b1);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && bytes_outstanding == 0) begin
            $display("stream_pattern_replace_unit: match");
        end else begin
            $display("stream_pattern_replace_unit: mismatch");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+src
src/spr_pkg.sv
src/spr_step.sv
src/stream_pattern_replace_unit.sv
verif/stream_pattern_replace_unit_checker.sv
verif/stream_pattern_replace_unit_test.sv
